@@ src/intel_hex_record_parser_macros.svh @@
// Assertion macros used by the checker of the Intel HEX record parser.
`ifndef INTEL_HEX_RECORD_PARSER_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define IHP_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("ihp assertion failed");

// Condition holds in the cycle after the trigger.
`define IHP_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("ihp assertion failed");

`endif

@@ src/ihp_pkg.sv @@
// Shared types and character constants of the Intel HEX record parser.
package ihp_pkg;

    localparam logic [7:0] CHR_COLON   = 8'h3A;
    localparam logic [7:0] CHR_0       = 8'h30;
    localparam logic [7:0] CHR_9       = 8'h39;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_F = 8'h46;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_F = 8'h66;
    localparam logic [7:0] CHR_NEWLINE = 8'h0A;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    localparam int ADDR_W = 17;

    // Decoded hex digit.
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_digit;

    // One result transaction.
    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_data;
        logic              end_seen;
    } t_result;

endpackage

@@ src/ihp_hex_digit.sv @@
// ASCII hex digit decoder.
module ihp_hex_digit (
    input  logic [7:0]      i_char,
    output ihp_pkg::t_digit o_digit
);

    logic [7:0] w_lower;
    logic [7:0] w_upper;
    logic [7:0] w_num;

    assign w_num   = i_char - ihp_pkg::CHR_0;
    assign w_upper = i_char - ihp_pkg::CHR_UPPER_A + 8'd10;
    assign w_lower = i_char - ihp_pkg::CHR_LOWER_A + 8'd10;

    always_comb begin
        o_digit = '0;
        if (i_char >= ihp_pkg::CHR_0 && i_char <= ihp_pkg::CHR_9) begin
            o_digit.ok    = 1'b1;
            o_digit.value = w_num[3:0];
        end else if (i_char >= ihp_pkg::CHR_UPPER_A && i_char <= ihp_pkg::CHR_UPPER_F) begin
            o_digit.ok    = 1'b1;
            o_digit.value = w_upper[3:0];
        end else if (i_char >= ihp_pkg::CHR_LOWER_A && i_char <= ihp_pkg::CHR_LOWER_F) begin
            o_digit.ok    = 1'b1;
            o_digit.value = w_lower[3:0];
        end
    end

endmodule

@@ src/ihp_parser.sv @@
// Record state machine and result register of the Intel HEX record parser.
module ihp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_char,
    output ihp_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        PH_START,
        PH_SKIP,
        PH_COUNT,
        PH_ADDRH,
        PH_ADDRL,
        PH_TYPE,
        PH_DATA,
        PH_TRAIL
    } t_phase;

    t_phase           r_phase,   n_phase;
    logic [3:0]       r_pend,    n_pend;
    logic             r_pend_bad, n_pend_bad;
    logic             r_half,    n_half;
    logic [7:0]       r_length,  n_length;
    logic [15:0]      r_base,    n_base;
    logic [7:0]       r_index,   n_index;
    logic             r_stopped, n_stopped;
    ihp_pkg::t_result r_result,  n_result;

    ihp_pkg::t_digit  w_digit;
    logic [7:0]       w_byte;
    logic [7:0]       w_index_inc;

    ihp_hex_digit u_digit (
        .i_char  (i_char),
        .o_digit (w_digit)
    );

    assign w_byte      = (r_pend_bad || !w_digit.ok) ? 8'h00 : {r_pend, w_digit.value};
    assign w_index_inc = r_index + 8'd1;

    always_comb begin
        n_phase    = r_phase;
        n_pend     = r_pend;
        n_pend_bad = r_pend_bad;
        n_half     = r_half;
        n_length   = r_length;
        n_base     = r_base;
        n_index    = r_index;
        n_stopped  = r_stopped;
        n_result   = '0;

        if (!r_stopped) begin
            if (i_char == ihp_pkg::CHR_NEWLINE) begin
                n_phase = PH_START;
                n_half  = 1'b0;
            end else if (r_phase == PH_START) begin
                n_phase = (i_char == ihp_pkg::CHR_COLON) ? PH_COUNT : PH_SKIP;
                n_half  = 1'b0;
            end else if (r_phase != PH_SKIP && r_phase != PH_TRAIL) begin
                if (!r_half) begin
                    n_pend     = w_digit.value;
                    n_pend_bad = !w_digit.ok;
                    n_half     = 1'b1;
                end else begin
                    n_half = 1'b0;
                    unique case (r_phase)
                        PH_COUNT: begin
                            n_length = w_byte;
                            n_phase  = PH_ADDRH;
                        end
                        PH_ADDRH: begin
                            n_base  = {w_byte, 8'h00};
                            n_phase = PH_ADDRL;
                        end
                        PH_ADDRL: begin
                            n_base  = {r_base[15:8], w_byte};
                            n_phase = PH_TYPE;
                        end
                        PH_TYPE: begin
                            n_index = 8'd0;
                            if (w_byte == ihp_pkg::REC_EOF) begin
                                n_stopped = 1'b1;
                                n_phase   = PH_TRAIL;
                            end else if (w_byte == ihp_pkg::REC_DATA && r_length != 8'd0) begin
                                n_phase = PH_DATA;
                            end else begin
                                n_phase = PH_TRAIL;
                            end
                        end
                        PH_DATA: begin
                            n_result.write_valid   = 1'b1;
                            n_result.write_address = {1'b0, r_base} + {9'd0, r_index};
                            n_result.write_data    = w_byte;
                            n_index                = w_index_inc;
                            if (w_index_inc >= r_length) begin
                                n_phase = PH_TRAIL;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
        end
        n_result.end_seen = n_stopped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_pend     <= 4'd0;
            r_pend_bad <= 1'b0;
            r_half     <= 1'b0;
            r_length   <= 8'd0;
            r_base     <= 16'd0;
            r_index    <= 8'd0;
            r_stopped  <= 1'b0;
            r_result   <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_pend     <= n_pend;
            r_pend_bad <= n_pend_bad;
            r_half     <= n_half;
            r_length   <= n_length;
            r_base     <= n_base;
            r_index    <= n_index;
            r_stopped  <= n_stopped;
            r_result   <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

@@ src/intel_hex_record_parser.sv @@
// Top level of the Intel HEX record parser: input register and handshake control.
//
// Usage:
//   Input channel carries one ASCII character of hex file text per transaction
//   (i_valid / o_stall / i_char_in). Output channel carries exactly one result
//   transaction per input character (o_valid / i_stall / o_write_*, o_end_seen).
//   A result with o_write_valid high is a data byte of a type 00 record at
//   o_write_address; otherwise address and data read zero. o_end_seen rises
//   with the end-of-file record and stays high; later characters are ignored.
// Path: a character taken lands in the input register, and its result is loaded
//   into the result register when the input register advances, which waits while
//   i_stall holds the previous result.
// Throughput: one character per cycle while i_stall is low; the record state
//   update is combinational decode logic between the input and result registers.
// Reset (i_rst_n low, synchronous): both registers empty, parser back at line
//   start, end flag cleared.
// Stall: while i_stall holds a result, the input register still takes one more
//   character; o_stall rises only when both registers are full.
module intel_hex_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_write_valid,
    output logic [16:0] o_write_address,
    output logic [7:0]  o_write_data,
    output logic        o_end_seen
);

    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_out_valid;
    logic             w_advance;
    logic             w_accept;
    ihp_pkg::t_result w_result;

    // Item moves from the input register into the result register.
    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    // Input register is blocked only when it is full and cannot drain.
    assign o_stall   = r_in_valid && r_out_valid && i_stall;
    assign w_accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload holds no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_char <= i_char_in;
        end
    end

    ihp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_char   (r_in_char),
        .o_result (w_result)
    );

    assign o_valid         = r_out_valid;
    assign o_write_valid   = w_result.write_valid;
    assign o_write_address = w_result.write_address;
    assign o_write_data    = w_result.write_data;
    assign o_end_seen      = w_result.end_seen;

endmodule

@@ src/ihp_checker.sv @@
// Port-level assertion checker for the Intel HEX record parser, with its bind.
`include "intel_hex_record_parser_macros.svh"

module ihp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_char_in,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_write_valid,
    input logic [16:0] o_write_address,
    input logic [7:0]  o_write_data,
    input logic        o_end_seen
);

    // Input blocks only behind a held result.
    `IHP_ASSERT_SAME(a_stall_needs_out, o_stall, o_valid && i_stall)
    // End flag is sticky until reset.
    `IHP_ASSERT_NEXT(a_end_sticky, o_end_seen, o_end_seen)
    // No byte write once the end record was seen.
    `IHP_ASSERT_SAME(a_no_write_after_end, o_valid && o_write_valid, !o_end_seen)
    // Non-write results carry zero address and data.
    `IHP_ASSERT_SAME(a_idle_zero, o_valid && !o_write_valid,
        o_write_address == 17'd0 && o_write_data == 8'd0)
    // Stalled result holds.
    `IHP_ASSERT_NEXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_write_address) && $stable(o_write_data))

endmodule

bind intel_hex_record_parser ihp_checker u_ihp_checker (.*);
